@@ rtl/core/json_string_unescape_assert.svh @@
// Assertion macros for the JSON string unescaper.
// Used by the top level; relies on clock and reset being in scope.
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// same-cycle implication
`define JSU_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/jsu_pkg.sv @@
// Shared types, constants and helper functions for the JSON string unescaper.
// No dependencies.
`default_nettype none

package jsu_pkg;

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // source characters
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U      = 8'h75;

   // surrogate tags (top six bits of a 16-bit unit)
   localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;

   // UTF-8 lead and continuation marks
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   localparam int MAX_RESULTS = 6;
   localparam int QUEUE_DEPTH = 4;   // power of two, pointers wrap
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       final_req;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] val;
      logic [1:0] kind;
   } res_type;

   // all results of one source byte
   typedef struct packed {
      logic [2:0]                   count;
      res_type [MAX_RESULTS-1:0]    res;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic [2:0]      count;
      logic [3:0][7:0] octets;
   } enc_type;

   function automatic logic hex_ok(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
             (b >= 8'h41 && b <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] b);
      logic [7:0] v;
      v = 8'h00;
      if (b >= 8'h30 && b <= 8'h39) v = b - 8'h30;
      else if (b >= 8'h61 && b <= 8'h66) v = b - 8'h57;
      else if (b >= 8'h41 && b <= 8'h46) v = b - 8'h37;
      return v[3:0];
   endfunction

   function automatic logic [7:0] esc_map(input logic [7:0] b);
      logic [7:0] v;
      case (b)
         8'h62: v = 8'h08;   // \b
         8'h66: v = 8'h0C;   // \f
         8'h6E: v = 8'h0A;   // \n
         8'h72: v = 8'h0D;   // \r
         8'h74: v = 8'h09;   // \t
         default: v = b;
      endcase
      return v;
   endfunction

   function automatic enc_type encode_cp(input logic [20:0] cp);
      enc_type e;
      e = '0;
      if (cp < 21'h80) begin
         e.count     = 3'd1;
         e.octets[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         e.count     = 3'd2;
         e.octets[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
         e.octets[1] = UTF8_CONT | {2'b00, cp[5:0]};
      end else if (cp < SUPP_BASE) begin
         e.count     = 3'd3;
         e.octets[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
         e.octets[1] = UTF8_CONT | {2'b00, cp[11:6]};
         e.octets[2] = UTF8_CONT | {2'b00, cp[5:0]};
      end else begin
         e.count     = 3'd4;
         e.octets[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
         e.octets[1] = UTF8_CONT | {2'b00, cp[17:12]};
         e.octets[2] = UTF8_CONT | {2'b00, cp[11:6]};
         e.octets[3] = UTF8_CONT | {2'b00, cp[5:0]};
      end
      return e;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/jsu_front.sv @@
// Front end: parses source bytes and builds at most one queue entry per byte.
// Depends on jsu_pkg.
`default_nettype none

module jsu_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire jsu_pkg::req_type req,
   output jsu_pkg::push_type     push
);

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_BODY     = 3'd1,
      PH_ESC      = 3'd2,
      PH_HEX      = 3'd3,
      PH_HELD     = 3'd4,
      PH_HELD_BS  = 3'd5,
      PH_HELD_HEX = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] hex_value_ff, hex_value_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [9:0]  pending_ff, pending_in;

   jsu_pkg::enc_type   enc_a, enc_b, high_enc;
   jsu_pkg::entry_type entry;
   logic [1:0]  sec_kind;
   logic        fail, do_body, do_esc, do_code, do_clear, dig_ok, done;
   logic [15:0] hv_next, code_val;
   logic [7:0]  b;
   logic [2:0]  j;

   always_comb begin
      b        = req.in_byte;
      phase_in = phase_ff;
      hex_value_in = hex_value_ff;
      hex_count_in = hex_count_ff;
      pending_in   = pending_ff;
      enc_a    = '0;
      enc_b    = '0;
      sec_kind = jsu_pkg::KIND_BYTE;
      fail     = 1'b0;
      do_body  = 1'b0;
      do_esc   = 1'b0;
      do_code  = 1'b0;
      do_clear = 1'b0;
      code_val = 16'h0000;
      dig_ok   = jsu_pkg::hex_ok(b);
      hv_next  = {hex_value_ff[11:0], jsu_pkg::hex_nibble(b)};
      done     = (hex_count_ff == 2'd3);
      high_enc = jsu_pkg::encode_cp({5'b00000, jsu_pkg::SURR_HIGH_TAG, pending_ff});

      case (phase_ff)
         PH_BODY: begin
            do_body = 1'b1;
         end
         PH_ESC: begin
            do_esc = 1'b1;
         end
         PH_HEX: begin
            if (!dig_ok) begin
               fail = 1'b1;
            end else begin
               hex_value_in = hv_next;
               if (done) begin
                  hex_count_in = 2'd0;
                  do_code      = 1'b1;
                  code_val     = hv_next;
               end else begin
                  hex_count_in = hex_count_ff + 2'd1;
               end
            end
         end
         PH_HELD: begin
            if (b == jsu_pkg::CHAR_BSLASH) begin
               phase_in = PH_HELD_BS;
            end else begin
               enc_a    = high_enc;
               phase_in = PH_BODY;
               do_body  = 1'b1;
            end
         end
         PH_HELD_BS: begin
            if (b == jsu_pkg::CHAR_U) begin
               phase_in     = PH_HELD_HEX;
               hex_value_in = 16'h0000;
               hex_count_in = 2'd0;
            end else begin
               enc_a  = high_enc;
               do_esc = 1'b1;
            end
         end
         PH_HELD_HEX: begin
            if (!dig_ok) begin
               fail = 1'b1;
            end else begin
               hex_value_in = hv_next;
               if (done) begin
                  hex_count_in = 2'd0;
                  if (hv_next[15:10] == jsu_pkg::SURR_LOW_TAG) begin
                     enc_b    = jsu_pkg::encode_cp(jsu_pkg::SUPP_BASE +
                                   {1'b0, pending_ff, hv_next[9:0]});
                     phase_in = PH_BODY;
                  end else begin
                     enc_a    = high_enc;
                     do_code  = 1'b1;
                     code_val = hv_next;
                  end
               end else begin
                  hex_count_in = hex_count_ff + 2'd1;
               end
            end
         end
         default: begin
            // idle, and the unused code
            do_clear = 1'b1;
            if (b != jsu_pkg::CHAR_QUOTE) fail = 1'b1;
         end
      endcase

      if (do_body) begin
         if (b == jsu_pkg::CHAR_QUOTE) begin
            enc_b.count = 3'd1;
            sec_kind    = jsu_pkg::KIND_CLOSE;
            do_clear    = 1'b1;
         end else if (b == jsu_pkg::CHAR_BSLASH) begin
            phase_in = PH_ESC;
         end else begin
            enc_b.count     = 3'd1;
            enc_b.octets[0] = b;
         end
      end

      if (do_esc) begin
         if (b == jsu_pkg::CHAR_U) begin
            phase_in     = PH_HEX;
            hex_value_in = 16'h0000;
            hex_count_in = 2'd0;
         end else begin
            enc_b.count     = 3'd1;
            enc_b.octets[0] = jsu_pkg::esc_map(b);
            phase_in        = PH_BODY;
         end
      end

      if (do_code) begin
         if (code_val[15:10] == jsu_pkg::SURR_HIGH_TAG) begin
            pending_in = code_val[9:0];
            phase_in   = PH_HELD;
         end else begin
            enc_b    = jsu_pkg::encode_cp({5'b00000, code_val});
            phase_in = PH_BODY;
         end
      end

      if (do_clear) begin
         phase_in     = PH_IDLE;
         hex_value_in = 16'h0000;
         hex_count_in = 2'd0;
         pending_in   = 10'h000;
      end
      // opening quote in idle enters the body
      if (phase_ff != PH_BODY && phase_ff != PH_ESC && phase_ff != PH_HEX &&
          phase_ff != PH_HELD && phase_ff != PH_HELD_BS && phase_ff != PH_HELD_HEX &&
          !fail) begin
         phase_in = PH_BODY;
      end

      // buffer ran out inside the string
      if (req.final_req && phase_in != PH_IDLE) fail = 1'b1;

      entry       = '0;
      entry.count = enc_a.count + enc_b.count;
      for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
         j = 3'(i) - enc_a.count;
         if (3'(i) < enc_a.count) begin
            entry.res[i].val  = enc_a.octets[i[1:0]];
            entry.res[i].kind = jsu_pkg::KIND_BYTE;
         end else if (j < enc_b.count) begin
            entry.res[i].val  = enc_b.octets[j[1:0]];
            entry.res[i].kind = sec_kind;
         end
      end

      if (fail) begin
         entry             = '0;
         entry.count       = 3'd1;
         entry.res[0].kind = jsu_pkg::KIND_ERROR;
         phase_in     = PH_IDLE;
         hex_value_in = 16'h0000;
         hex_count_in = 2'd0;
         pending_in   = 10'h000;
      end

      push.valid = accept && (entry.count != 3'd0);
      push.entry = entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hex_value_ff <= 16'h0000;
         hex_count_ff <= 2'd0;
         pending_ff   <= 10'h000;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hex_value_ff <= hex_value_in;
         hex_count_ff <= hex_count_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/jsu_queue.sv @@
// Entry queue between the parser front end and the result serializer.
// Depends on jsu_pkg.
`default_nettype none

module jsu_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire jsu_pkg::push_type  push,
   output logic                    full,
   input  wire logic               pop,
   output jsu_pkg::entry_type      head,
   output logic                    head_valid
);

   jsu_pkg::entry_type                    mem_ff [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QUEUE_AW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::QUEUE_AW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::QUEUE_CW-1:0]          count_ff, count_in;

   assign full       = (count_ff == jsu_pkg::QUEUE_CW'(jsu_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) count_in = count_ff + 1'b1;
      else if (!push.valid && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) mem_ff[wr_ptr_ff] <= push.entry;
   end

endmodule

`default_nettype wire

@@ rtl/core/jsu_back.sv @@
// Back end: walks the head entry one result per beat into the output register.
// Depends on jsu_pkg.
`default_nettype none

module jsu_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire jsu_pkg::entry_type head,
   input  wire logic               head_valid,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output jsu_pkg::rsp_type        rsp_payload
);

   logic [2:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   jsu_pkg::rsp_type rsp_payload_ff, rsp_payload_in;
   logic             load, at_end;

   always_comb begin
      load   = head_valid && (!rsp_valid_ff || !rsp_stall);
      at_end = (idx_ff == 3'(head.count - 3'd1));
      pop    = load && at_end;

      idx_in = idx_ff;
      if (pop) idx_in = 3'd0;
      else if (load) idx_in = idx_ff + 3'd1;

      rsp_valid_in = rsp_valid_ff;
      if (load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;

      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         rsp_payload_in.out_byte = head.res[idx_ff].val;
         rsp_payload_in.kind     = head.res[idx_ff].kind;
         rsp_payload_in.last     = at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

@@ rtl/core/json_string_unescape.sv @@
// JSON string literal unescaper. Feed the literal one source byte per beat,
// starting with the opening double quote; set final_req on the last byte of
// the source buffer. Each byte yields zero to six result beats: decoded bytes
// (kind 0, with \uXXXX escapes and surrogate pairs turned into UTF-8), a close
// beat (kind 1) on the closing quote, or a single error beat (kind 2) on a bad
// hex digit, a missing opening quote, or a buffer that ends inside the string;
// on error drop every byte already taken for that string. last marks the
// final beat caused by one source byte. Rate: one source byte per cycle while
// req_stall is low; the output side moves one result per cycle while rsp_stall
// is low, so a byte with k results holds the output until all k are out. A
// four-entry queue of per-byte result groups sits between the parser and
// the output serializer and absorbs such bursts; req_stall rises only when
// that queue is full. Results pass through the queue and the output register.
// Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back and the assertion header.
`default_nettype none

`include "json_string_unescape_assert.svh"

module json_string_unescape (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire jsu_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output jsu_pkg::rsp_type      rsp_payload
);

   jsu_pkg::push_type  push;
   jsu_pkg::entry_type head;
   logic               q_full;
   logic               head_valid;
   logic               pop;
   logic               accept;
   logic               term_beat;
   logic               term_ok;

   // input side only waits on queue space
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // parser: state machine plus result grouping
   jsu_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .push   (push)
   );

   // groups wait here while the output drains
   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (q_full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   // one result per beat, registered output
   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_valid  (head_valid),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // close or error beat on the output, and what it must look like
   assign term_beat = rsp_valid && (rsp_payload.kind != jsu_pkg::KIND_BYTE);
   assign term_ok   = rsp_payload.last && (rsp_payload.out_byte == 8'h00);

   // a group is never written into a full queue
   `JSU_ASSERT_IMPL(a_no_push_full, push.valid, !q_full, "push into full queue")
   // the serializer only retires a group that exists
   `JSU_ASSERT_IMPL(a_pop_nonempty, pop, head_valid, "pop from empty queue")
   // close and error beats are single, terminal and carry a zero byte
   `JSU_ASSERT_IMPL(a_term_last, term_beat, term_ok, "bad close or error beat")
   // a stalled group is not retired early
   `JSU_ASSERT_NEXT(a_head_held, head_valid && rsp_valid && rsp_stall, head_valid, "group lost under stall")

endmodule

`default_nettype wire

@@ bench/unescape_monitor.sv @@
// Channel monitor for the JSON string unescaper: tracks the parse state of the
// source stream, predicts every result beat and compares beats in order.
// Depends on jsu_pkg only.
`timescale 1ns / 1ps

module unescape_monitor
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      outstanding
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BODY,
      ST_ESC,
      ST_HEX,
      ST_HELD,
      ST_HELD_BS,
      ST_HELD_HEX
   } parse_state_e;

   localparam logic [7:0] ESC_BACKSPACE = "b";
   localparam logic [7:0] ESC_FORMFEED  = "f";
   localparam logic [7:0] ESC_NEWLINE   = "n";
   localparam logic [7:0] ESC_RETURN    = "r";
   localparam logic [7:0] ESC_TAB       = "t";
   localparam logic [5:0] HIGH_TAG      = 6'b110110;
   localparam logic [5:0] LOW_TAG       = 6'b110111;

   parse_state_e parse_state;
   logic [15:0]  unit_acc;
   logic [1:0]   digit_cnt;
   logic [9:0]   held_high;
   rsp_type      byte_beats[$];   // beats of the source byte being predicted
   rsp_type      due_beats[$];    // beats predicted but not yet seen

   task automatic reset_parser();
      parse_state = ST_IDLE;
      unit_acc    = '0;
      digit_cnt   = '0;
      held_high   = '0;
   endtask

   task automatic add_beat(input logic [7:0] val, input logic [1:0] kind);
      rsp_type one;
      one.out_byte = val;
      one.kind     = kind;
      one.last     = 1'b0;
      if (byte_beats.size() < MAX_RESULTS)
         byte_beats.push_back(one);
   endtask

   // error replaces whatever this byte produced so far
   task automatic abort_string();
      byte_beats.delete();
      add_beat(8'h00, KIND_ERROR);
      reset_parser();
   endtask

   task automatic put_utf8(input logic [20:0] cp);
      if (cp < 21'h80) begin
         add_beat(cp[7:0], KIND_BYTE);
      end else if (cp < 21'h800) begin
         add_beat({3'b110, cp[10:6]}, KIND_BYTE);
         add_beat({2'b10, cp[5:0]}, KIND_BYTE);
      end else if (cp < 21'h10000) begin
         add_beat({4'b1110, cp[15:12]}, KIND_BYTE);
         add_beat({2'b10, cp[11:6]}, KIND_BYTE);
         add_beat({2'b10, cp[5:0]}, KIND_BYTE);
      end else begin
         add_beat({5'b11110, cp[20:18]}, KIND_BYTE);
         add_beat({2'b10, cp[17:12]}, KIND_BYTE);
         add_beat({2'b10, cp[11:6]}, KIND_BYTE);
         add_beat({2'b10, cp[5:0]}, KIND_BYTE);
      end
   endtask

   task automatic plain_char(input logic [7:0] b);
      if (b == CHAR_QUOTE) begin
         add_beat(8'h00, KIND_CLOSE);
         reset_parser();
      end else if (b == CHAR_BSLASH) begin
         parse_state = ST_ESC;
      end else begin
         add_beat(b, KIND_BYTE);
      end
   endtask

   task automatic escaped_char(input logic [7:0] b);
      logic [7:0] val;
      val = b;
      if (b == CHAR_U) begin
         parse_state = ST_HEX;
         unit_acc    = '0;
         digit_cnt   = '0;
      end else begin
         case (b)
            ESC_BACKSPACE: val = 8'h08;
            ESC_FORMFEED:  val = 8'h0C;
            ESC_NEWLINE:   val = 8'h0A;
            ESC_RETURN:    val = 8'h0D;
            ESC_TAB:       val = 8'h09;
            default:       val = b;     // unknown escape keeps the character
         endcase
         add_beat(val, KIND_BYTE);
         parse_state = ST_BODY;
      end
   endtask

   task automatic take_digit(input logic [7:0] b, output logic ok, output logic done);
      logic [3:0] nib;
      ok   = 1'b1;
      done = 1'b0;
      nib  = '0;
      if (b >= "0" && b <= "9")
         nib = 4'(b - "0");
      else if (b >= "a" && b <= "f")
         nib = 4'(b - "a" + 8'd10);
      else if (b >= "A" && b <= "F")
         nib = 4'(b - "A" + 8'd10);
      else
         ok = 1'b0;
      if (ok) begin
         unit_acc = {unit_acc[11:0], nib};
         done     = (digit_cnt == 2'd3);
         digit_cnt = digit_cnt + 2'd1;
      end
   endtask

   // a complete \u unit outside a pair: hold a high half, else encode it
   task automatic unit_done(input logic [15:0] unit);
      if (unit[15:10] == HIGH_TAG) begin
         held_high   = unit[9:0];
         parse_state = ST_HELD;
      end else begin
         put_utf8({5'b0, unit});
         parse_state = ST_BODY;
      end
   endtask

   task automatic predict_beats(input req_type beat);
      logic [7:0]  b;
      logic [20:0] held_cp;
      logic        ok;
      logic        done;
      rsp_type     one;
      b       = beat.in_byte;
      held_cp = {5'b0, HIGH_TAG, held_high};
      byte_beats.delete();
      case (parse_state)
         ST_BODY: begin
            plain_char(b);
         end
         ST_ESC: begin
            escaped_char(b);
         end
         ST_HEX: begin
            take_digit(b, ok, done);
            if (!ok)
               abort_string();
            else if (done)
               unit_done(unit_acc);
         end
         ST_HELD: begin
            if (b == CHAR_BSLASH) begin
               parse_state = ST_HELD_BS;
            end else begin
               put_utf8(held_cp);
               parse_state = ST_BODY;
               plain_char(b);
            end
         end
         ST_HELD_BS: begin
            if (b == CHAR_U) begin
               parse_state = ST_HELD_HEX;
               unit_acc    = '0;
               digit_cnt   = '0;
            end else begin
               put_utf8(held_cp);
               escaped_char(b);
            end
         end
         ST_HELD_HEX: begin
            take_digit(b, ok, done);
            if (!ok) begin
               abort_string();
            end else if (done) begin
               if (unit_acc[15:10] == LOW_TAG) begin
                  put_utf8(21'h10000 + {1'b0, held_high, unit_acc[9:0]});
                  parse_state = ST_BODY;
               end else begin
                  put_utf8(held_cp);
                  unit_done(unit_acc);
               end
            end
         end
         default: begin
            reset_parser();
            if (b == CHAR_QUOTE)
               parse_state = ST_BODY;
            else
               abort_string();
         end
      endcase
      if (beat.final_req && parse_state != ST_IDLE)
         abort_string();
      foreach (byte_beats[i]) begin
         one      = byte_beats[i];
         one.last = (i == byte_beats.size() - 1);
         due_beats.push_back(one);
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got, inout int errs);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         reset_parser();
         due_beats.delete();
         fail_count  <= 0;
         outstanding <= 0;
      end else begin
         // results come out after their source byte is taken, so check first
         if (rsp_valid && !rsp_stall) begin
            if (due_beats.size() == 0) begin
               $error("result beat with nothing expected: out_byte 0x%0h kind %0d last %0b",
                      rsp_payload.out_byte, rsp_payload.kind, rsp_payload.last);
               errs++;
            end else begin
               want = due_beats.pop_front();
               check_field("out_byte", want.out_byte, rsp_payload.out_byte, errs);
               check_field("kind", {6'b0, want.kind}, {6'b0, rsp_payload.kind}, errs);
               check_field("last", {7'b0, want.last}, {7'b0, rsp_payload.last}, errs);
            end
         end
         if (req_valid && !req_stall)
            predict_beats(req_payload);
         fail_count  <= fail_count + errs;
         outstanding <= due_beats.size();
      end
   end

endmodule

@@ bench/tb_top.sv @@
// Top of the JSON string unescaper bench: clock, reset, source-byte stimulus,
// result back-pressure and the verdict. Depends on jsu_pkg, the block and
// unescape_monitor.
`timescale 1ns / 1ps

module tb_top;
   import jsu_pkg::*;

   localparam int SOURCE_BYTES  = 300;        // random part stops past this
   localparam int SETTLE_CYCLES = 16;
   localparam int LIMIT_NS      = 2_000_000;  // far beyond the slowest run

   // the simple escape letters, one per byte: " \ / b f n r t
   localparam logic [63:0] ESC_LETTERS = "\"\\/bfnrt";

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   int fail_count;
   int outstanding;

   // sender bookkeeping
   int      burst_left = 0;
   int      beats_sent = 0;
   req_type src_q[$];         // source bytes waiting to be sent

   // receiver back-pressure pattern
   logic [15:0] stall_pattern = '0;
   int          pattern_age   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   json_string_unescape dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   unescape_monitor mon (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Receiver: a 16-bit stall pattern rotates every cycle and is swapped for a
   // fresh one once its random age runs out. Modes: no stall at all, random, heavy
   // (OR of two randoms), and a long stall followed by a short release.
   always @(posedge clock) begin
      if (pattern_age == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_pattern <= 16'h0000;
            1:       stall_pattern <= 16'($urandom());
            2:       stall_pattern <= 16'($urandom() | $urandom());
            default: stall_pattern <= 16'hFFF0;
         endcase
         pattern_age <= $urandom_range(20, 80);
         rsp_stall   <= 1'b0;
      end else begin
         stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
         pattern_age   <= pattern_age - 1;
         rsp_stall     <= stall_pattern[15];
      end
   end

   //------------------------------------------------------------------
   // source construction helpers
   //------------------------------------------------------------------

   task automatic push_src(input logic [7:0] b, input logic fin);
      req_type beat;
      beat.in_byte   = b;
      beat.final_req = fin;
      src_q.push_back(beat);
   endtask

   // final_req goes on the last character only, if asked
   task automatic push_text(input string s, input logic fin_on_last);
      for (int i = 0; i < s.len(); i++)
         push_src(s[i], fin_on_last && (i == s.len() - 1));
   endtask

   function automatic logic [7:0] byte_other_than(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] b;
      do b = 8'($urandom()); while (b == x || b == y);
      return b;
   endfunction

   function automatic logic [7:0] bad_digit();
      logic [7:0] b;
      do
         b = 8'($urandom());
      while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
      return b;
   endfunction

   // hex letters come in either case, chosen per digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10)
         return "0" + {4'b0, nib};
      return (($urandom_range(0, 1) == 0) ? "a" : "A") + {4'b0, nib} - 8'd10;
   endfunction

   task automatic push_unit(input logic [15:0] unit);
      push_src(CHAR_BSLASH, 1'b0);
      push_src(CHAR_U, 1'b0);
      for (int i = 3; i >= 0; i--)
         push_src(hex_char(unit[4*i +: 4]), 1'b0);
   endtask

   // non-surrogate unit, spread over the 1-, 2- and 3-byte UTF-8 ranges
   function automatic logic [15:0] plain_unit();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(16'h0001, 16'h007F));
         3:       return 16'($urandom_range(16'h0080, 16'h07FF));
         4:       return 16'($urandom_range(16'h0800, 16'hD7FF));
         default: return 16'($urandom_range(16'hE000, 16'hFFFE));
      endcase
   endfunction

   function automatic logic [15:0] high_unit();
      return 16'($urandom_range(16'hD800, 16'hDBFF));
   endfunction

   function automatic logic [15:0] low_unit();
      return 16'($urandom_range(16'hDC00, 16'hDFFF));
   endfunction

   // One piece of string body. A lone high half is followed by whatever the
   // next piece happens to be: plain byte, escape, another \u or the quote.
   task automatic add_element();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         push_src(byte_other_than(CHAR_QUOTE, CHAR_BSLASH), 1'b0);
      end else if (pick < 55) begin
         push_src(CHAR_BSLASH, 1'b0);
         if ($urandom_range(0, 2) != 0)
            push_src(ESC_LETTERS[8*$urandom_range(0, 7) +: 8], 1'b0);
         else
            push_src(byte_other_than(CHAR_U, CHAR_U), 1'b0);   // unknown escape
      end else if (pick < 72) begin
         push_unit(plain_unit());
      end else if (pick < 88) begin
         push_unit(high_unit());
         push_unit(low_unit());
      end else if (pick < 95) begin
         push_unit(high_unit());
      end else begin
         push_unit(low_unit());
      end
   endtask

   // One string literal, mostly well formed. Endings: closing quote (now and
   // then marked final), buffer cut short at a random byte, or a bad hex
   // digit, sometimes right after a held high half. Stray bytes in the idle
   // phase come first now and then.
   task automatic build_string();
      int      first;
      int      cut;
      int      ending;
      req_type beat;
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3))
            push_src(byte_other_than(CHAR_QUOTE, CHAR_QUOTE), 1'($urandom_range(0, 1)));
      first = src_q.size();
      push_src(CHAR_QUOTE, 1'b0);
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6))
         add_element();
      ending = $urandom_range(0, 99);
      if (ending < 70) begin
         push_src(CHAR_QUOTE, $urandom_range(0, 4) == 0);
      end else if (ending < 85) begin
         // buffer ends inside the string, possibly on the opening quote
         cut            = $urandom_range(first, src_q.size() - 1);
         beat           = src_q[cut];
         beat.final_req = 1'b1;
         src_q[cut]     = beat;
         while (src_q.size() > cut + 1)
            void'(src_q.pop_back());
      end else begin
         if ($urandom_range(0, 1) == 1)
            push_unit(high_unit());
         push_src(CHAR_BSLASH, 1'b0);
         push_src(CHAR_U, 1'b0);
         repeat ($urandom_range(0, 3))
            push_src(hex_char(4'($urandom())), 1'b0);
         push_src(bad_digit(), 1'b0);
      end
   endtask

   //------------------------------------------------------------------
   // sender
   //------------------------------------------------------------------

   // Bursts of 1..12 beats (a quarter of them 30..60, i.e. no idling) with
   // idle gaps between. Valid is never dropped and raised at the same edge: the
   // gap waits on the clock in between.
   task automatic send_beat(input req_type beat);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic send_all();
      while (src_q.size() != 0)
         send_beat(src_q.pop_front());
   endtask

   // Hold off until every predicted beat has come out. The monitor updates
   // its count at the edge after the last accepted byte, hence a wait on that edge first.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   //------------------------------------------------------------------
   // main sequence
   //------------------------------------------------------------------

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: stray byte while idle
      push_src(8'hFF, 1'b0);
      // surrogate pair -> 4 bytes, then a held high half ended by a plain
      // byte, then the closing quote as the final byte of the buffer
      push_text("\"\\uD83D\\uDE00\\uDBFFx\"", 1'b1);
      // bad hex digit
      push_text("\"\\uG", 1'b0);
      // buffer ends on the opening quote
      push_text("\"", 1'b1);
      send_all();
      wait_drained();

      // random strings, with an occasional full drain in between
      while (beats_sent < SOURCE_BYTES) begin
         build_string();
         send_all();
         if ($urandom_range(0, 7) == 0)
            wait_drained();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
